### rtl/gasc_pkg.sv
// ----------------------------------------------------------------------------
// gasc_pkg
// Shared types and constants of the glyph alpha span coalescer: pixel and
// command item layouts, command codes and the queue entry that carries up to
// two commands from the front to the back.
// ----------------------------------------------------------------------------
package gasc_pkg;

  // longest span the front keeps open before it emits it
  localparam int unsigned MAX_GLYPH_WIDTH = 255;
  localparam int unsigned COUNT_W         = 8;
  localparam logic [7:0]  FULL_ALPHA      = 8'hFF;
  localparam logic [7:0]  ZERO_ALPHA      = 8'h00;
  localparam logic [COUNT_W-1:0] SPAN_FULL = COUNT_W'(MAX_GLYPH_WIDTH);

  // command codes
  localparam logic CMD_SPAN  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0]         alpha;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               row_end;
  } gasc_pixel_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] start_x;
    logic signed [15:0] row_y;
    logic [7:0]         span_length;
    logic [7:0]         coverage;
    logic               last;
  } gasc_cmd_t;

  // one queue entry: first command, optional second command
  typedef struct packed {
    gasc_cmd_t first;
    gasc_cmd_t second;
    logic      has_second;
  } gasc_entry_t;

endpackage

### rtl/gasc_front.sv
// ----------------------------------------------------------------------------
// gasc_front
// Classifies each pixel item, keeps the open span and builds the commands
// that the item causes as one queue entry. Items that cause no command only
// update the span state.
// ----------------------------------------------------------------------------
module gasc_front import gasc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  gasc_pixel_t pixel,
  input  logic        q_full,
  output logic        q_push,
  output gasc_entry_t q_entry
);

  logic [COUNT_W-1:0] open_count, open_count_next;
  logic [15:0]        open_start, open_start_next;

  logic        is_opaque, is_zero, accept;
  logic        pre_flush, restart, post_cmd;
  gasc_cmd_t   pre_cmd, post_span, post_blend, post;
  logic [COUNT_W-1:0] grown_count;
  logic [15:0]        grown_start;

  assign pixel_ready = !q_full;
  assign accept      = pixel_valid && pixel_ready;

  // classify
  assign is_opaque = (pixel.alpha == FULL_ALPHA);
  assign is_zero   = (pixel.alpha == ZERO_ALPHA);

  // pending span goes out first: full span on opaque, any span otherwise
  assign pre_flush = is_opaque ? (open_count == SPAN_FULL) : (open_count != '0);
  assign restart   = (open_count == SPAN_FULL) || (open_count == '0);

  // span after an opaque pixel joins it
  assign grown_count = restart ? COUNT_W'(1) : open_count + COUNT_W'(1);
  assign grown_start = restart ? pixel.pixel_x : open_start;

  // second command: opaque at row end emits the grown span, partial a blend
  assign post_cmd = is_opaque ? pixel.row_end : !is_zero;

  always_comb begin
    pre_cmd.command     = CMD_SPAN;
    pre_cmd.start_x     = open_start;
    pre_cmd.row_y       = pixel.pixel_y;
    pre_cmd.span_length = open_count;
    pre_cmd.coverage    = FULL_ALPHA;
    pre_cmd.last        = !post_cmd;

    post_span.command     = CMD_SPAN;
    post_span.start_x     = grown_start;
    post_span.row_y       = pixel.pixel_y;
    post_span.span_length = grown_count;
    post_span.coverage    = FULL_ALPHA;
    post_span.last        = 1'b1;

    post_blend.command     = CMD_BLEND;
    post_blend.start_x     = pixel.pixel_x;
    post_blend.row_y       = pixel.pixel_y;
    post_blend.span_length = 8'd1;
    post_blend.coverage    = pixel.alpha;
    post_blend.last        = 1'b1;

    post = is_opaque ? post_span : post_blend;

    // pack commands in order into the entry
    if (pre_flush) begin
      q_entry.first      = pre_cmd;
      q_entry.second     = post;
      q_entry.has_second = post_cmd;
    end else begin
      q_entry.first      = post;
      q_entry.second     = post;
      q_entry.has_second = 1'b0;
    end
  end

  assign q_push = accept && (pre_flush || post_cmd);

  // next span state
  always_comb begin
    open_start_next = open_start;
    if (is_opaque) begin
      open_start_next = grown_start;
      open_count_next = pixel.row_end ? '0 : grown_count;
    end else begin
      open_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
      open_start <= '0;
    end else if (accept) begin
      open_count <= open_count_next;
      open_start <= open_start_next;
    end
  end

endmodule

### rtl/gasc_queue.sv
// ----------------------------------------------------------------------------
// gasc_queue
// Small first-in first-out queue of command entries between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module gasc_queue import gasc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  gasc_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output gasc_entry_t head,
  output logic [Q_CNT_W-1:0] fill
);

  gasc_entry_t        slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;

  assign full      = (fill == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/gasc_back.sv
// ----------------------------------------------------------------------------
// gasc_back
// Drains queue entries into the command output register, one command per
// cycle unless cmd_ready stalls; an entry's two commands go out in order.
// ----------------------------------------------------------------------------
module gasc_back import gasc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  gasc_entry_t q_head,
  output logic        q_pop,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output gasc_cmd_t   cmd,
  output logic        second_phase
);

  logic load;

  // output register free or being taken this cycle
  assign load  = !cmd_valid || cmd_ready;
  assign q_pop = load && q_not_empty && (second_phase || !q_head.has_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid    <= 1'b0;
      second_phase <= 1'b0;
    end else if (load) begin
      cmd_valid <= q_not_empty;
      if (q_not_empty) begin
        second_phase <= !second_phase && q_head.has_second;
      end
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (load && q_not_empty) begin
      cmd <= second_phase ? q_head.second : q_head.first;
    end
  end

endmodule

### rtl/glyph_alpha_span_coalescer_top.sv
// ----------------------------------------------------------------------------
// glyph_alpha_span_coalescer_top
// Turns glyph alpha pixels into foreground span and blended pixel commands.
//
//   channel  direction  payload        handshake
//   pixel    in         gasc_pixel_t   pixel_valid / pixel_ready
//   cmd      out        gasc_cmd_t     cmd_valid / cmd_ready
//
// One pixel item is taken per cycle while the four-entry queue has room.
// The first command of an item goes from its queue slot into the back's
// output register; the back emits one command per cycle while cmd_ready
// allows, and an item causing two commands sends its first, then its second.
// Reset clears the open span, the queue pointers and the output register.
// A stalled cmd channel fills the queue, then pixel_ready drops.
// ----------------------------------------------------------------------------
module glyph_alpha_span_coalescer_top import gasc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  gasc_pixel_t pixel,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output gasc_cmd_t   cmd
);

  logic               q_full, q_push, q_pop, q_not_empty, second_phase;
  gasc_entry_t        q_entry, q_head;
  logic [Q_CNT_W-1:0] q_fill;

  // classify and build commands
  gasc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // decoupling queue
  gasc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head),
    .fill       (q_fill)
  );

  // command output
  gasc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .second_phase (second_phase)
  );

`ifndef SYNTHESIS
  // span commands carry full coverage and a nonzero length
  a_span_shape: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd.command == CMD_SPAN) |-> (cmd.coverage == FULL_ALPHA) &&
      (cmd.span_length != 8'd0))
    else $error("span command with bad coverage or length");

  // blended pixels are single pixels ending their item
  a_blend_shape: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd.command == CMD_BLEND) |-> (cmd.span_length == 8'd1) && cmd.last)
    else $error("blend command malformed");

  // second half of an entry is only pending while its entry is still queued
  a_phase_queued: assert property (@(posedge clk) disable iff (rst)
    second_phase |-> q_not_empty && q_head.has_second)
    else $error("second command pending without queued entry");

  // queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_fill <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill out of range");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glyph_alpha_span_coalescer_top. Streams glyph alpha
// pixels through the valid/ready pixel channel and checks every draw command
// on the cmd channel against an in-bench rasterizer that tracks the open
// opaque span. Covers the field extremes, each pixel class, the full-span
// rollover and random glyph rows, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb import gasc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_PIXELS  = 250;
  localparam int STRETCH_OFFSET = 60;
  localparam int STRETCH_PIXELS = 100;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_ready;
  gasc_pixel_t pixel       = '0;
  logic        cmd_valid;
  logic        cmd_ready   = 1'b0;
  gasc_cmd_t   cmd;

  // open span as the rasterizer sees it
  logic [COUNT_W-1:0] run_count = '0;
  logic signed [15:0] run_start = '0;

  // draw commands owed by the block, oldest first
  gasc_cmd_t pending_draws[$];
  gasc_cmd_t held_draw;
  bit        draw_held   = 1'b0;

  int  fail_count      = 0;
  int  mismatch_count  = 0;
  int  pixels_sent     = 0;
  bit  no_idle_stretch = 1'b0;

  glyph_alpha_span_coalescer_top dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  always #5 clk = ~clk;

  function automatic gasc_pixel_t make_pixel(input int a, input int x, input int y,
                                             input bit re);
    gasc_pixel_t p;
    p.alpha   = 8'(a);
    p.pixel_x = 16'(x);
    p.pixel_y = 16'(y);
    p.row_end = re;
    return p;
  endfunction

  function automatic gasc_cmd_t make_draw(input logic code, input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic [7:0] len, input logic [7:0] cov);
    gasc_cmd_t c;
    c.command     = code;
    c.start_x     = x;
    c.row_y       = y;
    c.span_length = len;
    c.coverage    = cov;
    c.last        = 1'b0;
    return c;
  endfunction

  // hold back the newest draw so the final one of a pixel can be marked last
  function automatic void add_draw(input gasc_cmd_t c);
    if (draw_held) pending_draws.push_back(held_draw);
    held_draw = c;
    draw_held = 1'b1;
  endfunction

  function automatic void close_span(input logic signed [15:0] y);
    if (run_count != '0) begin
      add_draw(make_draw(CMD_SPAN, run_start, y, run_count, FULL_ALPHA));
      run_count = '0;
    end
  endfunction

  // draw commands caused by one pixel
  function automatic void rasterize_pixel(input gasc_pixel_t p);
    if (p.alpha == FULL_ALPHA) begin
      if (run_count >= SPAN_FULL) close_span(p.pixel_y);
      if (run_count == '0) run_start = p.pixel_x;
      run_count++;
    end else if (p.alpha == ZERO_ALPHA) begin
      close_span(p.pixel_y);
    end else begin
      close_span(p.pixel_y);
      add_draw(make_draw(CMD_BLEND, p.pixel_x, p.pixel_y, 8'd1, p.alpha));
    end
    if (p.row_end) close_span(p.pixel_y);
    if (draw_held) begin
      held_draw.last = 1'b1;
      pending_draws.push_back(held_draw);
      draw_held = 1'b0;
    end
  endfunction

  // drive one pixel item and wait until it is taken
  task automatic send_pixel(input gasc_pixel_t p);
    if (!no_idle_stretch && $urandom_range(99) < 24) begin
      pixel_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 24);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (!pixel_ready);
    rasterize_pixel(p);
    pixels_sent++;
  endtask

  // hold the pixel channel until every owed draw is out, then let the block settle
  task automatic settle_draws();
    pixel_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // field extremes, every pixel class and the row-end cases
  task automatic test_directed_pixels();
    // transparent with nothing open, then a partial pixel at the corner values
    send_pixel(make_pixel(0, -32768, 32767, 1'b0));
    send_pixel(make_pixel(1, 32767, -32768, 1'b0));
    // opaque run closed by the row end on its last pixel
    send_pixel(make_pixel(255, 10, 5, 1'b0));
    send_pixel(make_pixel(255, 11, 5, 1'b0));
    send_pixel(make_pixel(255, 12, 5, 1'b1));
    // partial pixel closes the span before its blend
    send_pixel(make_pixel(255, 20, 6, 1'b0));
    send_pixel(make_pixel(254, 21, 6, 1'b0));
    // transparent pixel closes a lone opaque pixel
    send_pixel(make_pixel(255, 30, 7, 1'b0));
    send_pixel(make_pixel(0, 31, 7, 1'b0));
    // column gap and row change without row end keep the span open
    send_pixel(make_pixel(255, 40, 8, 1'b0));
    send_pixel(make_pixel(255, 100, 8, 1'b0));
    send_pixel(make_pixel(255, 0, 9, 1'b0));
    send_pixel(make_pixel(0, 1, 10, 1'b0));
    // partial pixel at row end after an open span
    send_pixel(make_pixel(255, 50, 11, 1'b0));
    send_pixel(make_pixel(128, 51, 11, 1'b1));
    // partial pixel at row end with nothing open
    send_pixel(make_pixel(127, -1, -1, 1'b1));
    // transparent at row end, with and without an open span
    send_pixel(make_pixel(255, -200, -2, 1'b0));
    send_pixel(make_pixel(0, -199, -2, 1'b1));
    send_pixel(make_pixel(0, 0, 0, 1'b1));
    // lone opaque pixel at row end
    send_pixel(make_pixel(255, -32768, -32768, 1'b1));
    // span across the column wrap, row taken from the closing pixel
    send_pixel(make_pixel(255, 32767, 32767, 1'b0));
    send_pixel(make_pixel(255, -32768, 32767, 1'b0));
    send_pixel(make_pixel(255, 21845, 10922, 1'b1));
    settle_draws();
  endtask

  // opaque runs that reach the span limit
  task automatic test_full_span();
    int i;
    // full span rolls over at an opaque row-end pixel: two spans from one item
    for (i = 0; i < int'(MAX_GLYPH_WIDTH); i++) send_pixel(make_pixel(255, 100 + i, -3, 1'b0));
    send_pixel(make_pixel(255, 355, -3, 1'b1));
    // rollover without row end, then a partial pixel at row end
    for (i = 0; i < int'(MAX_GLYPH_WIDTH); i++) send_pixel(make_pixel(255, -600 + i, 77, 1'b0));
    send_pixel(make_pixel(255, -345, 77, 1'b0));
    send_pixel(make_pixel(200, -344, 77, 1'b1));
    settle_draws();
  endtask

  // random glyphs: mostly proper rows, some with broken row ends and coordinates
  task automatic test_random_glyphs();
    int          stop_at;
    int          stretch_from;
    int          width;
    int          rows;
    int          r;
    int          c;
    int          sel;
    bit          noisy;
    logic [15:0] org_x;
    logic [15:0] org_y;
    gasc_pixel_t p;
    stop_at      = pixels_sent + RANDOM_PIXELS;
    stretch_from = pixels_sent + STRETCH_OFFSET;
    while (pixels_sent < stop_at) begin
      org_x = 16'($urandom);
      org_y = 16'($urandom);
      width = ($urandom_range(9) == 0) ? int'($urandom_range(17, 48))
                                       : int'($urandom_range(1, 12));
      rows  = int'($urandom_range(1, 6));
      noisy = ($urandom_range(99) < 15);
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < width; c++) begin
          sel = int'($urandom_range(9));
          if (sel < 4)      p.alpha = FULL_ALPHA;
          else if (sel < 6) p.alpha = ZERO_ALPHA;
          else if (sel < 9) p.alpha = 8'($urandom_range(1, 254));
          else              p.alpha = 8'($urandom);
          p.pixel_x = org_x + 16'(c);
          p.pixel_y = org_y + 16'(r);
          p.row_end = (c == width - 1);
          if (noisy) begin
            if ($urandom_range(3) == 0) p.row_end = 1'($urandom_range(1));
            if ($urandom_range(3) == 0) p.pixel_x = 16'($urandom);
            if ($urandom_range(3) == 0) p.pixel_y = 16'($urandom);
          end
          // a long run of pixels with no idling on either side
          no_idle_stretch = (pixels_sent >= stretch_from) &&
                            (pixels_sent < stretch_from + STRETCH_PIXELS);
          send_pixel(p);
        end
      end
      // now and then let the command side run dry
      if ($urandom_range(19) == 0) settle_draws();
    end
    no_idle_stretch = 1'b0;
    settle_draws();
  endtask

  // command side: random stalls, compare each taken item with the oldest owed draw
  always @(posedge clk) begin : draw_monitor
    gasc_cmd_t want;
    logic      bad;
    if (!rst && cmd_valid && cmd_ready) begin
      if (pending_draws.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected draw: cmd=%0d x=%0d y=%0d len=%0d cov=%0d last=%0d",
                   cmd.command, cmd.start_x, cmd.row_y, cmd.span_length,
                   cmd.coverage, cmd.last);
      end else begin
        want = pending_draws.pop_front();
        bad  = 1'b0;
        if (cmd.command !== want.command)         bad = 1'b1;
        if (cmd.start_x !== want.start_x)         bad = 1'b1;
        if (cmd.row_y !== want.row_y)             bad = 1'b1;
        if (cmd.span_length !== want.span_length) bad = 1'b1;
        if (cmd.coverage !== want.coverage)       bad = 1'b1;
        if (cmd.last !== want.last)               bad = 1'b1;
        if (bad) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("draw mismatch: want cmd=%0d x=%0d y=%0d len=%0d cov=%0d last=%0d, %s",
                     want.command, want.start_x, want.row_y, want.span_length,
                     want.coverage, want.last, "got:");
          if (mismatch_count <= 10)
            $display("               got  cmd=%0d x=%0d y=%0d len=%0d cov=%0d last=%0d",
                     cmd.command, cmd.start_x, cmd.row_y, cmd.span_length,
                     cmd.coverage, cmd.last);
        end
      end
    end
    cmd_ready <= no_idle_stretch || ($urandom_range(99) >= 24);
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_pixels();
    test_full_span();
    test_random_glyphs();
    if (pending_draws.size() != 0) begin
      fail_count++;
      $display("%0d draw commands never came out", pending_draws.size());
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
